@@ hw/rtl/vpa_pkg.sv @@
//------------------------------------------------------------------------------
// vpa_pkg: shared types and constants for the variable partition allocator
// Holds table geometry, status codes, the sequencer states and the per-cycle
// control word that the sequencer hands to every table cell.
//------------------------------------------------------------------------------
package vpa_pkg;

    localparam int NumEntries = 16;
    localparam int AddrBits   = 16;
    localparam int SizeBits   = AddrBits + 1;
    localparam int IdxBits    = $clog2(NumEntries);
    localparam int CntBits    = $clog2(NumEntries + 1);
    localparam int LimitBits  = 16;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADADDR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_RSVD  = 2'd3
    } fit_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_MERGE,
        S_DONE
    } state_t;

    // Cell operations for one cycle
    typedef enum logic [2:0] {
        OP_HOLD,   // keep contents
        OP_ROT,    // take right neighbor, last slot takes slot 0 (scan rotation)
        OP_INS,    // split/insert step
        OP_DEL,    // delete step: take right neighbor
        OP_CLR     // clear to zero
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IdxBits-1:0]  idx;      // target position (insert/delete)
        logic [AddrBits-1:0] ins_base;
        logic [SizeBits-1:0] ins_size;
        logic                ins_free;
        logic                wr_en;    // write target index fields
        logic [SizeBits-1:0] wr_size;
        logic                wr_free;
    } cell_ctl_t;

    typedef struct packed {
        logic [AddrBits-1:0] base;
        logic [SizeBits-1:0] size;
        logic                free;
    } entry_t;

endpackage

@@ hw/rtl/vpa_cell.sv @@
//------------------------------------------------------------------------------
// vpa_cell: one table slot
// Holds one partition entry. Shifts toward higher slots on insert, toward
// lower slots on delete and on rotate, and takes a direct write at its index.
//------------------------------------------------------------------------------
module vpa_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [vpa_pkg::IdxBits-1:0]           my_idx,
    input  vpa_pkg::entry_t                       rst_val,
    input  vpa_pkg::cell_ctl_t                    ctl,
    input  vpa_pkg::entry_t                       left_in,
    input  vpa_pkg::entry_t                       right_in,
    input  vpa_pkg::entry_t                       ring_in,
    output vpa_pkg::entry_t                       ent
);

    vpa_pkg::entry_t ent_reg;
    vpa_pkg::entry_t ent_next;

    always_comb begin
        ent_next = ent_reg;
        unique case (ctl.op)
            vpa_pkg::OP_HOLD: ;
            vpa_pkg::OP_ROT:  ent_next = ring_in;
            vpa_pkg::OP_INS: begin
                if (my_idx > ctl.idx) begin
                    ent_next = left_in;
                end
                if (my_idx == ctl.idx) begin
                    ent_next.base = ctl.ins_base;
                    ent_next.size = ctl.ins_size;
                    ent_next.free = ctl.ins_free;
                end
            end
            vpa_pkg::OP_DEL: begin
                if (my_idx >= ctl.idx) begin
                    ent_next = right_in;
                end
            end
            vpa_pkg::OP_CLR: ent_next = '0;
            default: ;
        endcase
        if (ctl.wr_en && my_idx == ctl.idx && ctl.op == vpa_pkg::OP_HOLD) begin
            ent_next.size = ctl.wr_size;
            ent_next.free = ctl.wr_free;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= rst_val;
        end else begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

@@ hw/rtl/vpa_table.sv @@
//------------------------------------------------------------------------------
// vpa_table: row of partition cells
// Chains the cells as a ring; the last slot feeds from slot 0 on rotate.
//------------------------------------------------------------------------------
module vpa_table (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  vpa_pkg::cell_ctl_t         ctl,
    output vpa_pkg::entry_t            ents [vpa_pkg::NumEntries]
);

    localparam vpa_pkg::entry_t ZeroEnt = '0;

    for (genvar g = 0; g < vpa_pkg::NumEntries; g++) begin : g_cell
        vpa_pkg::entry_t rst_val;
        vpa_pkg::entry_t left_in;
        vpa_pkg::entry_t right_in;
        vpa_pkg::entry_t ring_in;

        always_comb begin
            rst_val = ZeroEnt;
            if (g == 0) begin
                rst_val.size = vpa_pkg::SizeBits'(1) << vpa_pkg::AddrBits;
                rst_val.free = 1'b1;
            end
        end

        assign left_in  = ents[(g + vpa_pkg::NumEntries - 1) % vpa_pkg::NumEntries];
        assign right_in = (g == vpa_pkg::NumEntries - 1) ? ZeroEnt
                        : ents[(g + 1) % vpa_pkg::NumEntries];
        assign ring_in  = ents[(g + 1) % vpa_pkg::NumEntries];

        vpa_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .my_idx   (vpa_pkg::IdxBits'(g)),
            .rst_val  (rst_val),
            .ctl      (ctl),
            .left_in  (left_in),
            .right_in (right_in),
            .ring_in  (ring_in),
            .ent      (ents[g])
        );
    end

endmodule

@@ hw/rtl/variable_partition_allocator_core.sv @@
//------------------------------------------------------------------------------
// variable_partition_allocator_core: dynamic partition allocator
// Keeps an address-ordered table of partitions; allocates by first, best or
// worst fit with splitting and frees with neighbor merging.
//
// Usage:
//   s_tdata beats carry one request (allocate or free); m_tdata returns one
//   status beat per request. Configuration goes through the APB-style port
//   (fit policy at 0x0, leftover limit at 0x4); the user must configure it
//   only while idle, which the core does not enforce. One request is worked
//   at a time. The table rotates once through slot 0 to scan, then a decide
//   step follows; a split adds a shift step, and a free adds a merge step
//   plus a size write and a delete per merged neighbor.
//   The result sits in an output register; the next request is taken as soon
//   as the result is loaded there, so a stalled receiver holds only the
//   result beat and stalls input once a second result is ready.
//   Reset leaves one free partition covering the whole address space, fit
//   policy first fit, leftover limit 0.
//------------------------------------------------------------------------------
module variable_partition_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // req_size[16:0], free_addr[32:17], zeros
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], granted_addr[17:2],
                                   // granted_size[34:18], zeros
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N  = vpa_pkg::NumEntries;
    localparam int IB = vpa_pkg::IdxBits;
    localparam int CB = vpa_pkg::CntBits;
    localparam int AB = vpa_pkg::AddrBits;
    localparam int SB = vpa_pkg::SizeBits;
    localparam logic [2:0] AddrPolicy = 3'd0;
    localparam logic [2:0] AddrLimit  = 3'd4;

    // configuration
    logic [1:0]                    policy_reg;
    logic [vpa_pkg::LimitBits-1:0] limit_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= vpa_pkg::FIT_FIRST;
            limit_reg  <= '0;
        end else if (cfg_wr) begin
            if (paddr == AddrPolicy) policy_reg <= pwdata[1:0];
            if (paddr == AddrLimit)  limit_reg  <= pwdata[vpa_pkg::LimitBits-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == AddrPolicy) prdata = {30'd0, policy_reg};
        if (paddr == AddrLimit)  prdata = {16'd0, limit_reg};
    end

    // table
    vpa_pkg::cell_ctl_t ctl;
    vpa_pkg::entry_t    ents [N];

    vpa_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .ents    (ents)
    );

    // control registers
    vpa_pkg::state_t state_reg, state_next;
    logic            kind_reg;
    logic [SB-1:0]   req_reg;
    logic [AB-1:0]   faddr_reg;
    logic [CB-1:0]   count_reg, count_next;
    logic [CB-1:0]   step_reg, step_next;      // rotation position
    logic            found_reg, found_next;
    logic [IB-1:0]   pick_reg, pick_next;
    logic [SB-1:0]   psize_reg, psize_next;
    logic [AB-1:0]   pbase_reg, pbase_next;
    logic            pfree_reg, pfree_next;
    logic [1:0]      res_st_reg, res_st_next;
    logic [AB-1:0]   res_a_reg, res_a_next;
    logic [SB-1:0]   res_s_reg, res_s_next;
    logic            ovalid_reg;
    logic [39:0]     odata_reg;
    logic            load_out;

    // the entry currently rotated into slot 0 has original index step_reg
    vpa_pkg::entry_t head;
    logic            live;
    logic            cand;
    logic            better;
    logic [SB-1:0]   leftover;
    logic [SB-1:0]   merged;
    logic            mdel_left, mdel_right;

    assign head = ents[0];
    assign live = step_reg < count_reg;

    always_comb begin
        cand   = live && head.free && (head.size >= req_reg);
        better = 1'b0;
        unique case (vpa_pkg::fit_t'(policy_reg))
            vpa_pkg::FIT_BEST:  better = head.size < psize_reg;
            vpa_pkg::FIT_WORST: better = head.size > psize_reg;
            default:            better = 1'b0;
        endcase
    end

    assign leftover = psize_reg - req_reg;

    // merge neighbors: after decide, pick_reg entry is at its slot
    logic [IB-1:0] idx_p1;
    assign idx_p1 = pick_reg + IB'(1);
    assign mdel_left  = (pick_reg != '0) && ents[pick_reg - IB'(1)].free;
    assign mdel_right = ({1'b0, pick_reg} + CB'(1) < count_reg) && ents[idx_p1].free;
    assign merged = mdel_left ? ents[pick_reg - IB'(1)].size + ents[pick_reg].size
                              : ents[pick_reg].size + ents[idx_p1].size;

    assign s_tready = (state_reg == vpa_pkg::S_IDLE);
    assign load_out = (state_reg == vpa_pkg::S_DONE) && (!ovalid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vpa_pkg::S_IDLE:   if (s_tvalid) state_next = vpa_pkg::S_SCAN;
            vpa_pkg::S_SCAN:   if (step_reg == CB'(N - 1)) state_next = vpa_pkg::S_DECIDE;
            vpa_pkg::S_DECIDE: begin
                if (kind_reg == vpa_pkg::KIND_FREE && found_reg && !pfree_reg) begin
                    state_next = vpa_pkg::S_MERGE;
                end else if (kind_reg == vpa_pkg::KIND_ALLOC && found_reg
                             && req_reg != '0 && leftover > SB'(limit_reg)
                             && count_reg < CB'(N)) begin
                    state_next = vpa_pkg::S_SHIFT;
                end else begin
                    state_next = vpa_pkg::S_DONE;
                end
            end
            vpa_pkg::S_SHIFT:  state_next = vpa_pkg::S_DONE;
            vpa_pkg::S_MERGE:  if (!mdel_left && !mdel_right) state_next = vpa_pkg::S_DONE;
            vpa_pkg::S_DONE:   if (load_out) state_next = vpa_pkg::S_IDLE;
            default:           state_next = vpa_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        ctl         = '0;
        ctl.op      = vpa_pkg::OP_HOLD;
        count_next  = count_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        pick_next   = pick_reg;
        psize_next  = psize_reg;
        pbase_next  = pbase_reg;
        pfree_next  = pfree_reg;
        res_st_next = res_st_reg;
        res_a_next  = res_a_reg;
        res_s_next  = res_s_reg;
        unique case (state_reg)
            vpa_pkg::S_IDLE: begin
                step_next  = '0;
                found_next = 1'b0;
            end
            vpa_pkg::S_SCAN: begin
                ctl.op    = vpa_pkg::OP_ROT;
                step_next = step_reg + CB'(1);
                if (kind_reg == vpa_pkg::KIND_ALLOC) begin
                    if (cand && (!found_reg || better)) begin
                        found_next = 1'b1;
                        pick_next  = step_reg[IB-1:0];
                        psize_next = head.size;
                        pbase_next = head.base;
                        pfree_next = head.free;
                    end
                end else if (live && !found_reg && head.base == faddr_reg) begin
                    found_next = 1'b1;
                    pick_next  = step_reg[IB-1:0];
                    pfree_next = head.free;
                end
            end
            vpa_pkg::S_DECIDE: begin
                res_st_next = vpa_pkg::ST_OK;
                res_a_next  = '0;
                res_s_next  = '0;
                if (kind_reg == vpa_pkg::KIND_FREE) begin
                    if (!found_reg || pfree_reg) begin
                        res_st_next = vpa_pkg::ST_BADADDR;
                    end else begin
                        ctl.wr_en   = 1'b1;
                        ctl.idx     = pick_reg;
                        ctl.wr_size = ents[pick_reg].size;
                        ctl.wr_free = 1'b1;
                    end
                end else if (!found_reg || req_reg == '0) begin
                    res_st_next = vpa_pkg::ST_NOFIT;
                end else if (leftover <= SB'(limit_reg)) begin
                    ctl.wr_en   = 1'b1;
                    ctl.idx     = pick_reg;
                    ctl.wr_size = psize_reg;
                    ctl.wr_free = 1'b0;
                    res_a_next  = pbase_reg;
                    res_s_next  = psize_reg;
                end else if (count_reg >= CB'(N)) begin
                    res_st_next = vpa_pkg::ST_FULL;
                end else begin
                    ctl.wr_en   = 1'b1;
                    ctl.idx     = pick_reg;
                    ctl.wr_size = req_reg;
                    ctl.wr_free = 1'b0;
                    res_a_next  = pbase_reg;
                    res_s_next  = req_reg;
                end
            end
            vpa_pkg::S_SHIFT: begin
                ctl.op       = vpa_pkg::OP_INS;
                ctl.idx      = idx_p1;
                ctl.ins_base = pbase_reg + req_reg[AB-1:0];
                ctl.ins_size = leftover;
                ctl.ins_free = 1'b1;
                count_next   = count_reg + CB'(1);
            end
            vpa_pkg::S_MERGE: begin
                // fold free neighbors in one at a time: size write, then delete
                if (mdel_left) begin
                    ctl.wr_en   = 1'b1;
                    ctl.idx     = pick_reg - IB'(1);
                    ctl.wr_size = merged;
                    ctl.wr_free = 1'b1;
                    // deleting the picked slot happens via two-step: write left,
                    // then delete; done next cycle by moving pick left
                    pick_next   = pick_reg - IB'(1);
                    psize_next  = '1;  // marks pending delete
                end else if (mdel_right) begin
                    ctl.wr_en   = 1'b1;
                    ctl.idx     = pick_reg;
                    ctl.wr_size = merged;
                    ctl.wr_free = 1'b1;
                    psize_next  = '0;
                end
                if (psize_reg == '1) begin
                    // pending removal of slot pick_reg+1 (absorbed entry)
                    ctl       = '0;
                    ctl.op    = vpa_pkg::OP_DEL;
                    ctl.idx   = idx_p1;
                    count_next = count_reg - CB'(1);
                    psize_next = '0;
                    pick_next  = pick_reg;
                end else if (psize_reg == SB'(1)) begin
                    ctl       = '0;
                    ctl.op    = vpa_pkg::OP_DEL;
                    ctl.idx   = idx_p1;
                    count_next = count_reg - CB'(1);
                    psize_next = '0;
                    pick_next  = pick_reg;
                end else if (!mdel_left && mdel_right) begin
                    psize_next = SB'(1);
                end
            end
            vpa_pkg::S_DONE: ;
            default: ;
        endcase
    end

    logic merge_busy;
    assign merge_busy = (psize_reg == '1) || (psize_reg == SB'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= vpa_pkg::S_IDLE;
            count_reg  <= CB'(1);
            step_reg   <= '0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            psize_reg  <= '0;
        end else begin
            if (state_reg == vpa_pkg::S_MERGE && merge_busy) begin
                state_reg <= vpa_pkg::S_MERGE;
            end else if (state_reg == vpa_pkg::S_DECIDE
                         && state_next == vpa_pkg::S_MERGE) begin
                state_reg <= vpa_pkg::S_MERGE;
            end else begin
                state_reg <= state_next;
            end
            count_reg <= count_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            psize_reg <= (state_reg == vpa_pkg::S_DECIDE
                          && state_next == vpa_pkg::S_MERGE) ? '0 : psize_next;
            if (load_out) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            req_reg   <= s_tdata[SB-1:0];
            faddr_reg <= s_tdata[SB+AB-1:SB];
        end
        pick_reg   <= pick_next;
        pbase_reg  <= pbase_next;
        pfree_reg  <= pfree_next;
        res_st_reg <= res_st_next;
        res_a_reg  <= res_a_next;
        res_s_reg  <= res_s_next;
        if (load_out) begin
            odata_reg <= {5'd0, res_s_reg, res_a_reg, res_st_reg};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

endmodule

@@ sim/tb_top.sv @@
//------------------------------------------------------------------------------
// tb_top: stream testbench for the variable partition allocator
// Tracks its own partition table, predicts each status beat and compares the
// returned beats in order. Walks through the fit policies and leftover limits
// with random allocate/free traffic and random stalls on both sides.
//------------------------------------------------------------------------------
module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [2:0] REG_FIT   = 3'd0;
    localparam logic [2:0] REG_LIMIT = 3'd4;

    variable_partition_allocator_core uut (.*);

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [16:0] size;
    } request_t;

    // model table
    logic [15:0] tbl_base [vpa_pkg::NumEntries];
    logic [16:0] tbl_size [vpa_pkg::NumEntries];
    logic        tbl_free [vpa_pkg::NumEntries];
    int          tbl_count;
    logic [1:0]  cur_fit;
    logic [15:0] cur_limit;

    request_t    pending_reqs[$];
    logic [39:0] expected_beats[$];
    int          errors = 0;
    int          send_idle = 9;
    int          recv_idle = 88;

    function automatic logic [39:0] pack_result(vpa_pkg::status_t st, logic [15:0] a,
                                                logic [16:0] sz);
        pack_result = {5'd0, sz, a, st};
    endfunction

    function automatic logic [39:0] predict_result(request_t r);
        int chosen, lo, hi, gap;
        logic [16:0] left;
        logic [16:0] sum;
        chosen = -1;
        if (r.kind == vpa_pkg::KIND_ALLOC) begin
            if (r.size == 0) return pack_result(vpa_pkg::ST_NOFIT, '0, '0);
            for (int i = 0; i < tbl_count; i++) begin
                if (!tbl_free[i] || tbl_size[i] < r.size) continue;
                if (chosen < 0) begin
                    chosen = i;
                    if (cur_fit != vpa_pkg::FIT_BEST && cur_fit != vpa_pkg::FIT_WORST) break;
                end else if (cur_fit == vpa_pkg::FIT_BEST
                             && tbl_size[i] < tbl_size[chosen]) begin
                    chosen = i;
                end else if (cur_fit == vpa_pkg::FIT_WORST
                             && tbl_size[i] > tbl_size[chosen]) begin
                    chosen = i;
                end
            end
            if (chosen < 0) return pack_result(vpa_pkg::ST_NOFIT, '0, '0);
            left = tbl_size[chosen] - r.size;
            if (left <= {1'b0, cur_limit}) begin
                tbl_free[chosen] = 1'b0;
                return pack_result(vpa_pkg::ST_OK, tbl_base[chosen], tbl_size[chosen]);
            end
            if (tbl_count >= vpa_pkg::NumEntries) return pack_result(vpa_pkg::ST_FULL, '0, '0);
            for (int j = tbl_count; j > chosen + 1; j--) begin
                tbl_base[j] = tbl_base[j-1];
                tbl_size[j] = tbl_size[j-1];
                tbl_free[j] = tbl_free[j-1];
            end
            tbl_base[chosen+1] = tbl_base[chosen] + r.size[15:0];
            tbl_size[chosen+1] = left;
            tbl_free[chosen+1] = 1'b1;
            tbl_count++;
            tbl_size[chosen] = r.size;
            tbl_free[chosen] = 1'b0;
            return pack_result(vpa_pkg::ST_OK, tbl_base[chosen], r.size);
        end
        for (int i = 0; i < tbl_count; i++)
            if (tbl_base[i] == r.addr) begin
                chosen = i;
                break;
            end
        if (chosen < 0 || tbl_free[chosen]) return pack_result(vpa_pkg::ST_BADADDR, '0, '0);
        tbl_free[chosen] = 1'b1;
        lo = chosen;
        while (lo > 0 && tbl_free[lo-1]) lo--;
        hi = chosen;
        while (hi + 1 < tbl_count && tbl_free[hi+1]) hi++;
        sum = '0;
        for (int j = lo; j <= hi; j++) sum += tbl_size[j];
        tbl_size[lo] = sum;
        gap = hi - lo;
        if (gap > 0) begin
            for (int j = lo + 1; j + gap < tbl_count; j++) begin
                tbl_base[j] = tbl_base[j+gap];
                tbl_size[j] = tbl_size[j+gap];
                tbl_free[j] = tbl_free[j+gap];
            end
            for (int j = tbl_count - gap; j < tbl_count; j++) begin
                tbl_base[j] = '0;
                tbl_size[j] = '0;
                tbl_free[j] = 1'b0;
            end
            tbl_count -= gap;
        end
        return pack_result(vpa_pkg::ST_OK, '0, '0);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            expected_beats.push_back(predict_result(pending_reqs.pop_front()));
        end
        if ((!s_tvalid || s_tready) && aresetn) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_reqs[0].kind;
                s_tdata  <= {7'd0, pending_reqs[0].addr, pending_reqs[0].size};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    // monitor
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                logic [39:0] exp_beat;
                exp_beat = expected_beats.pop_front();
                if (exp_beat !== m_tdata) begin
                    $display("%0t mismatch: expected st=%0d a=%h sz=%h actual st=%0d a=%h sz=%h",
                             $time, exp_beat[1:0], exp_beat[17:2], exp_beat[34:18],
                             m_tdata[1:0], m_tdata[17:2], m_tdata[34:18]);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] a, logic [31:0] d);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == REG_FIT) cur_fit = d[1:0];
        else cur_limit = d[15:0];
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic void add_req(logic kind, logic [16:0] sz, logic [15:0] a);
        request_t r;
        r.kind = kind; r.size = sz; r.addr = a;
        pending_reqs.push_back(r);
    endfunction

    // random addresses lean on live bases so frees mostly hit
    logic [15:0] live_bases[$];

    function automatic void random_phase(int n, int max_sz);
        for (int i = 0; i < n; i++) begin
            int p;
            p = $urandom_range(99);
            if (p < 50)
                add_req(vpa_pkg::KIND_ALLOC, 17'($urandom_range(max_sz, 1)), 16'($urandom));
            else if (p < 85 && live_bases.size() > 0)
                add_req(vpa_pkg::KIND_FREE, 17'($urandom),
                        live_bases[$urandom_range(live_bases.size() - 1)]);
            else if (p < 92)
                add_req(vpa_pkg::KIND_ALLOC, 17'($urandom), 16'($urandom));
            else
                add_req(vpa_pkg::KIND_FREE, 17'($urandom), 16'($urandom));
        end
    endfunction

    task automatic run_batch(int n, int max_sz);
        // rebuild candidate base list from model table before each chunk
        for (int c = 0; c < n; c += 10) begin
            live_bases.delete();
            for (int i = 0; i < tbl_count; i++) live_bases.push_back(tbl_base[i]);
            random_phase(10, max_sz);
            while (pending_reqs.size() > 0) @(posedge aclk);
        end
    endtask

    initial begin
        tbl_base = '{default: '0};
        tbl_size = '{default: '0};
        tbl_free = '{default: 1'b0};
        tbl_size[0] = 17'h10000;
        tbl_free[0] = 1'b1;
        tbl_count = 1;
        cur_fit = vpa_pkg::FIT_FIRST;
        cur_limit = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, special cases, full table
        add_req(vpa_pkg::KIND_ALLOC, 17'd0, 16'd0);
        add_req(vpa_pkg::KIND_ALLOC, 17'h1FFFF, 16'hFFFF);
        add_req(vpa_pkg::KIND_FREE, 17'd0, 16'd0);
        add_req(vpa_pkg::KIND_ALLOC, 17'h10000, 16'd0);
        add_req(vpa_pkg::KIND_FREE, 17'h1FFFF, 16'hFFFF);
        add_req(vpa_pkg::KIND_FREE, 17'd0, 16'd0);
        add_req(vpa_pkg::KIND_FREE, 17'd0, 16'd0);
        for (int i = 0; i < 16; i++) add_req(vpa_pkg::KIND_ALLOC, 17'd1, 16'd0);
        add_req(vpa_pkg::KIND_FREE, 17'd0, 16'd1);
        add_req(vpa_pkg::KIND_FREE, 17'd0, 16'd2);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin send_idle = 88; recv_idle = 9; end
            if (ph == 6) begin send_idle = 0;  recv_idle = 0; end
            case (ph % 4)
                0: reg_write(REG_FIT, 32'(vpa_pkg::FIT_BEST));
                1: reg_write(REG_FIT, 32'(vpa_pkg::FIT_WORST));
                2: reg_write(REG_FIT, 32'(vpa_pkg::FIT_RSVD));
                default: reg_write(REG_FIT, 32'(vpa_pkg::FIT_FIRST));
            endcase
            case (ph % 3)
                0: reg_write(REG_LIMIT, 32'hFFFF);
                1: reg_write(REG_LIMIT, 32'($urandom_range(64)));
                default: reg_write(REG_LIMIT, 32'd0);
            endcase
            run_batch(180, (ph == 8) ? 65536 : ($urandom_range(1) ? 8192 : 512));
            drain();
        end

        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
